// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the renumbering block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define FORN_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("renumbering assertion failed");
// Condition must never be true outside reset.
`define FORN_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("renumbering forbidden condition seen");
`else
`define FORN_ASSERT(lbl, clk, rst_n, prop)
`define FORN_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/forn_pkg.sv -----
// Types and field widths shared by the renumbering block.
package forn_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned DENSE_ID_W = 6;
	localparam int unsigned COUNT_W    = 7;

	// Flags and payload of one identifier as it walks down the cell row
	typedef struct packed {
		logic [VALUE_W-1:0] node_value;
		logic               first_item;
		logic               last_item;
		logic               found;    // matched a stored slot
		logic               claimed;  // stored into a free slot
	} item_t;

endpackage

// ----- rtl/forn_ifs.sv -----
// Valid/ready channel interfaces for identifier and result beats.
interface forn_ident_if;
	logic                             valid;
	logic                             ready;
	logic [forn_pkg::VALUE_W-1:0]     node_value;
	logic                             first_item;
	logic                             last_item;

	modport source (output valid, node_value, first_item, last_item, input ready);
	modport sink   (input valid, node_value, first_item, last_item, output ready);
endinterface

interface forn_result_if;
	logic                             valid;
	logic                             ready;
	logic [forn_pkg::DENSE_ID_W-1:0]  dense_id;
	logic                             is_new;
	logic [forn_pkg::COUNT_W-1:0]     distinct_count;
	logic                             overflow;
	logic                             last_out;

	modport source (output valid, dense_id, is_new, distinct_count, overflow, last_out,
		input ready);
	modport sink   (input valid, dense_id, is_new, distinct_count, overflow, last_out,
		output ready);
endinterface

// ----- rtl/forn_cell.sv -----
// One table slot of the renumbering row, with the stage register to its neighbor.
module forn_cell #(
	parameter int unsigned IdW   = 6,
	parameter int unsigned CntW  = 7,
	parameter int unsigned Index = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  prev_valid,
	input  forn_pkg::item_t       prev_item,
	input  logic [IdW-1:0]        prev_id,
	input  logic [CntW-1:0]       prev_count,
	output logic                  next_valid,
	output forn_pkg::item_t       next_item,
	output logic [IdW-1:0]        next_id,
	output logic [CntW-1:0]       next_count
);

	logic [forn_pkg::VALUE_W-1:0] stored_q;
	logic                         occupied_q;
	logic                         valid_q;
	forn_pkg::item_t              item_q;
	logic [IdW-1:0]               id_q;
	logic [CntW-1:0]              count_q;

	logic            occ_eff;
	logic            hit;
	logic            claim;
	logic            move;
	forn_pkg::item_t item_d;

	// A set-opening beat sees the slot as free; it clears it on the way past
	assign occ_eff = occupied_q & ~prev_item.first_item;
	assign hit     = occ_eff & ~prev_item.found & ~prev_item.claimed
		& (stored_q == prev_item.node_value);
	assign claim   = ~occ_eff & ~prev_item.found & ~prev_item.claimed;
	assign move    = advance & prev_valid;

	always_comb begin
		item_d         = prev_item;
		item_d.found   = prev_item.found | hit;
		item_d.claimed = prev_item.claimed | claim;
	end

	// Slot contents
	always_ff @(posedge clk) begin
		if (move && claim) begin
			stored_q <= prev_item.node_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
		end else if (move) begin
			if (claim) begin
				occupied_q <= 1'b1;
			end else if (prev_item.first_item) begin
				occupied_q <= 1'b0;
			end
		end
	end

	// Stage register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			item_q  <= item_d;
			id_q    <= (hit || claim) ? IdW'(Index) : prev_id;
			count_q <= prev_count + CntW'(occ_eff | claim);
		end
	end

	assign next_valid = valid_q;
	assign next_item  = item_q;
	assign next_id    = id_q;
	assign next_count = count_q;

endmodule

// ----- rtl/first_occurrence_renumbering.sv -----
// Top level: identifier renumbering over a row of compare-and-store cells.
// An accepted identifier beat passes the stage register of every cell before its result beat.
// Throughput: one beat per cycle unless the result beat is held; each beat visits one
// table cell per cycle and later beats trail earlier ones, so they see every slot stored
// before them. Reset clears all slot occupancy and the stage valids; no clearing pass.
`include "assert_macros.svh"

module first_occurrence_renumbering #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	forn_ident_if.sink      ident,
	forn_result_if.source   result
);

	localparam int unsigned IdW  = $clog2(TABLE_DEPTH);
	localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

	logic            chain_valid [TABLE_DEPTH+1];
	forn_pkg::item_t chain_item  [TABLE_DEPTH+1];
	logic [IdW-1:0]  chain_id    [TABLE_DEPTH+1];
	logic [CntW-1:0] chain_count [TABLE_DEPTH+1];
	logic            advance;
	logic            out_valid;
	logic            out_found;
	logic            out_claimed;
	logic [IdW-1:0]  out_id;
	logic [CntW-1:0] out_count;
	logic            out_overflow;

	// Whole row moves unless the result beat is held
	assign advance     = !out_valid || result.ready;
	assign ident.ready = advance;

	// Row entry
	assign chain_valid[0] = ident.valid;
	assign chain_item[0]  = '{
		node_value: ident.node_value,
		first_item: ident.first_item,
		last_item:  ident.last_item,
		found:      1'b0,
		claimed:    1'b0
	};
	assign chain_id[0]    = '0;
	assign chain_count[0] = '0;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		forn_cell #(
			.IdW   (IdW),
			.CntW  (CntW),
			.Index (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (advance),
			.prev_valid (chain_valid[k]),
			.prev_item  (chain_item[k]),
			.prev_id    (chain_id[k]),
			.prev_count (chain_count[k]),
			.next_valid (chain_valid[k+1]),
			.next_item  (chain_item[k+1]),
			.next_id    (chain_id[k+1]),
			.next_count (chain_count[k+1])
		);
	end

	// Result beat from the end of the row
	assign out_valid    = chain_valid[TABLE_DEPTH];
	assign out_found    = chain_item[TABLE_DEPTH].found;
	assign out_claimed  = chain_item[TABLE_DEPTH].claimed;
	assign out_id       = chain_id[TABLE_DEPTH];
	assign out_count    = chain_count[TABLE_DEPTH];
	assign out_overflow = !out_found && !out_claimed;

	assign result.valid          = out_valid;
	assign result.dense_id       = out_overflow ? '0 : forn_pkg::DENSE_ID_W'(out_id);
	assign result.is_new         = out_claimed;
	assign result.distinct_count = forn_pkg::COUNT_W'(out_count);
	assign result.overflow       = out_overflow;
	assign result.last_out       = chain_item[TABLE_DEPTH].last_item;

	// A full table means every slot was counted
	`FORN_ASSERT(a_ovf_full, clk, arst_n, out_valid && out_overflow |-> out_count == CntW'(TABLE_DEPTH))
	// A freshly stored identifier takes the next number in its set
	`FORN_ASSERT(a_new_count, clk, arst_n, out_valid && out_claimed |-> out_count == CntW'(out_id) + CntW'(1))
	// A match points inside the occupied part of the table
	`FORN_ASSERT(a_hit_inside, clk, arst_n, out_valid && out_found |-> out_count > CntW'(out_id))
	// Never both matched and stored
	`FORN_NEVER(a_hit_and_store, clk, arst_n, out_valid && out_found && out_claimed)

endmodule
